// ===== hdl/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg - shared types and constants of the unicycle pose integrator
// Holds the sequencer states, register indexes, fixed-point constants and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package upi_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DONE
  } state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_X       = 2'd0,
    CFG_START_Y       = 2'd1,
    CFG_START_HEADING = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  // widths of the datapath
  localparam int unsigned DIV_W = 34;  // divider numerator / quotient
  localparam int unsigned COR_W = 34;  // cordic vector and angle
  localparam int unsigned MAG_W = 24;  // magnitude of the distance step
  localparam int unsigned PRD_W = MAG_W + COR_W + 1;

  // fixed-point constants
  localparam int unsigned MAX_STEPS   = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [18:0] HEAD_SCALE2 = 19'd333772;  // twice 65536/(2*pi)/4096 in Q16

  // arctangent of 2^-i, angle units of 2^32 per turn
  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/unicycle_pose_integrator.sv =====
// A tick without a new command goes from idle straight to the done state; a
//   commanded tick runs a 34-bit serial division, then a 24-bit serial multiply;
//   the cordic runs beside the division.
// Ticks are taken one at a time; the next transfer is taken in the cycle after the
//   result is stored.
// Reset: synchronous active-low; pose and held command clear to zero.
// ----------------------------------------------------------------------------
// unicycle_pose_integrator - forward Euler odometry for a unicycle model
// Stores a velocity command and advances x, y, heading on commanded ticks only.
// ----------------------------------------------------------------------------
`default_nettype none

module unicycle_pose_integrator import upi_pkg::*; #(
  parameter int unsigned TICK_RATE_HZ = 20,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_new_command,
  input  wire logic signed [15:0] in_linear_speed,
  input  wire logic signed [15:0] in_angular_speed,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pose_x,
  output logic signed [31:0]      out_pose_y,
  output logic [15:0]             out_pose_heading,
  output logic signed [15:0]      out_echo_linear,
  output logic signed [15:0]      out_echo_angular,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int unsigned RATE = (TICK_RATE_HZ < 1) ? 1 : TICK_RATE_HZ;
  localparam logic [DIV_W-1:0] DEN_D = DIV_W'(2 * RATE);
  localparam logic [DIV_W-1:0] DEN_H = DIV_W'(64'(2 * RATE) * 64'd65536);
  localparam logic [DIV_W-1:0] BIAS_D = DIV_W'(RATE);
  localparam logic [DIV_W-1:0] BIAS_H = DIV_W'(64'(RATE) * 64'd65536);

  state_t state_r, state_nxt;

  logic signed [31:0] pos_x_r, pos_y_r;
  logic [15:0]        heading_r;
  logic signed [15:0] held_lin_r, held_ang_r;
  logic               neg_v_r, neg_w_r, cmd_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [15:0]        out_h_r;
  logic signed [15:0] out_lin_r, out_ang_r;

  logic               in_xfer, slot_free, go_calc, go_mul, finish;
  logic [15:0]        mag_v, mag_w;
  logic [DIV_W-1:0]   num_d, num_h, quo_d, quo_h;
  logic               busy_dd, busy_dh, busy_cor, busy_mx, busy_my;
  logic signed [COR_W-1:0] cos_v, sin_v;
  logic signed [PRD_W-1:0] prod_x, prod_y, sprod_x, sprod_y;
  logic signed [63:0] rnd_x, rnd_y;
  logic signed [31:0] new_x, new_y;
  logic [15:0]        dh, new_h;

  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // operand magnitudes and rounding numerators
  always_comb begin
    mag_v = in_linear_speed[15] ? 16'(-in_linear_speed) : 16'(in_linear_speed);
    mag_w = in_angular_speed[15] ? 16'(-in_angular_speed) : 16'(in_angular_speed);
    num_d = DIV_W'({mag_v, 9'b0}) + BIAS_D;
    num_h = DIV_W'(DIV_W'(mag_w) * DIV_W'(HEAD_SCALE2)) + BIAS_H;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = in_new_command ? ST_CALC : ST_DONE;
      ST_CALC: if (!busy_dd && !busy_dh && !busy_cor) state_nxt = ST_MUL;
      ST_MUL:  if (!busy_mx && !busy_my) state_nxt = ST_DONE;
      ST_DONE: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    go_calc  = 1'b0;
    go_mul   = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        go_calc  = in_valid && in_new_command;
      end
      ST_CALC: go_mul = !busy_dd && !busy_dh && !busy_cor;
      ST_MUL:  ;
      ST_DONE: finish = slot_free;
      default: ;
    endcase
  end

  upi_div u_div_d (
    .clk, .rst_n, .start(go_calc), .num(num_d), .den(DEN_D), .busy(busy_dd), .quo(quo_d)
  );

  upi_div u_div_h (
    .clk, .rst_n, .start(go_calc), .num(num_h), .den(DEN_H), .busy(busy_dh), .quo(quo_h)
  );

  upi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(go_calc), .heading(heading_r), .busy(busy_cor),
    .cos_o(cos_v), .sin_o(sin_v)
  );

  upi_mul u_mul_x (
    .clk, .rst_n, .start(go_mul), .mag(quo_d[MAG_W-1:0]), .mcand(cos_v),
    .busy(busy_mx), .prod(prod_x)
  );

  upi_mul u_mul_y (
    .clk, .rst_n, .start(go_mul), .mag(quo_d[MAG_W-1:0]), .mcand(sin_v),
    .busy(busy_my), .prod(prod_y)
  );

  // signed displacement, rounded and scaled back to Q16.16
  always_comb begin
    sprod_x = neg_v_r ? -prod_x : prod_x;
    sprod_y = neg_v_r ? -prod_y : prod_y;
    rnd_x   = 64'(sprod_x) + 64'sd536870912;
    rnd_y   = 64'(sprod_y) + 64'sd536870912;
    dh      = neg_w_r ? 16'(-quo_h[15:0]) : quo_h[15:0];
    new_x   = cmd_r ? (pos_x_r + rnd_x[61:30]) : pos_x_r;
    new_y   = cmd_r ? (pos_y_r + rnd_y[61:30]) : pos_y_r;
    new_h   = cmd_r ? (heading_r + dh) : heading_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pose and held command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      heading_r  <= '0;
      held_lin_r <= '0;
      held_ang_r <= '0;
      cmd_r      <= 1'b0;
      neg_v_r    <= 1'b0;
      neg_w_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_START_X:       pos_x_r   <= cfg_data;
          CFG_START_Y:       pos_y_r   <= cfg_data;
          CFG_START_HEADING: heading_r <= cfg_data[15:0];
          CFG_UNUSED:        ;
          default:           ;
        endcase
      end
      if (in_xfer) begin
        cmd_r <= in_new_command;
        if (in_new_command) begin
          held_lin_r <= in_linear_speed;
          held_ang_r <= in_angular_speed;
          neg_v_r    <= in_linear_speed[15];
          neg_w_r    <= in_angular_speed[15];
        end
      end
      if (finish) begin
        pos_x_r   <= new_x;
        pos_y_r   <= new_y;
        heading_r <= new_h;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_x_r   <= new_x;
      out_y_r   <= new_y;
      out_h_r   <= new_h;
      out_lin_r <= held_lin_r;
      out_ang_r <= held_ang_r;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_pose_x       = out_x_r;
  assign out_pose_y       = out_y_r;
  assign out_pose_heading = out_h_r;
  assign out_echo_linear  = out_lin_r;
  assign out_echo_angular = out_ang_r;

  // checks
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a tick is in work");

  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (!busy_dd && !busy_dh && !busy_cor))
    else $error("multiply running before division and cordic finished");

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("sequencer did not leave idle after a transfer");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("finished tick not presented on the result channel");

endmodule

`default_nettype wire

// ===== hdl/upi_div.sv =====
// ----------------------------------------------------------------------------
// upi_div - radix-2 restoring divider
// One quotient bit per cycle, numerator shifted in from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_div import upi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic                  busy,
  output logic [DIV_W-1:0]      quo
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [DIV_W:0]   trial;
  logic             qbit;

  // trial subtract of one step
  always_comb begin
    trial   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? (trial - {1'b0, den_r}) : trial;
    quo_nxt = {quo_r[DIV_W-2:0], qbit};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== hdl/upi_cordic.sv =====
// ----------------------------------------------------------------------------
// upi_cordic - iterative rotation-mode cordic
// Folds the heading into the right half plane, then runs one micro-rotation
// per cycle; gives cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_cordic import upi_pkg::*; #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [15:0]             heading,
  output logic                         busy,
  output logic signed [COR_W-1:0]      cos_o,
  output logic signed [COR_W-1:0]      sin_o
);

  localparam int unsigned NSTEP = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [COR_W-1:0] x_r, y_r, z_r;
  logic signed [COR_W-1:0] x_sh, y_sh, atan_s;
  logic [4:0]              i_r;
  logic                    busy_r, neg_r;
  logic                    fold;
  logic [15:0]             h_fold;

  // fold into -90..+90 degrees
  assign fold   = (heading >= 16'h4000) && (heading < 16'hC000);
  assign h_fold = fold ? (heading ^ 16'h8000) : heading;

  // shifted terms of one micro-rotation
  always_comb begin
    x_sh   = x_r >>> i_r;
    y_sh   = y_r >>> i_r;
    atan_s = COR_W'(atan_val(i_r));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      if (i_r == 5'(NSTEP - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // vector and angle registers
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= COR_W'(CORDIC_GAIN);
      y_r   <= '0;
      z_r   <= COR_W'($signed({h_fold, 16'h0000}));
      neg_r <= fold;
    end else if (busy_r) begin
      if (!z_r[COR_W-1]) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_s;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_s;
      end
    end
  end

  assign busy  = busy_r;
  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;

endmodule

`default_nettype wire

// ===== hdl/upi_mul.sv =====
// ----------------------------------------------------------------------------
// upi_mul - bit-serial shift-add multiplier
// Unsigned magnitude times signed multiplicand, one magnitude bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module upi_mul import upi_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [MAG_W-1:0]        mag,
  input  wire logic signed [COR_W-1:0] mcand,
  output logic                         busy,
  output logic signed [PRD_W-1:0]      prod
);

  localparam int unsigned CW = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]        mag_r;
  logic signed [COR_W-1:0] mc_r;
  logic signed [PRD_W-1:0] acc_r;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(MAG_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // accumulate: acc = 2*acc + bit*mcand
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      mc_r  <= mcand;
      acc_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[MAG_W-2:0], 1'b0};
      acc_r <= (acc_r <<< 1) + (mag_r[MAG_W-1] ? PRD_W'(mc_r) : '0);
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

`default_nettype wire
